/* hdl/stcp_pkg.sv */
// Shared types, constants and helper functions for the serial time/command parser.
// Used by stcp_line_parser, stcp_result_store and serial_time_command_parser.
package stcp_pkg;

    localparam int LINE_LIMIT_DEFAULT = 128;

    localparam int ACC_W   = 14;
    localparam int FIELD_W = ACC_W + 1;
    localparam int NUM_FIELDS = 6;

    localparam logic [ACC_W-1:0] ACC_MAX = 14'd16383;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    localparam logic [2:0] KIND_TIME     = 3'd0;
    localparam logic [2:0] KIND_OTHER    = 3'd1;
    localparam logic [2:0] KIND_IP       = 3'd2;
    localparam logic [2:0] KIND_SSID     = 3'd3;
    localparam logic [2:0] KIND_POT      = 3'd4;
    localparam logic [2:0] KIND_POT_BAD  = 3'd5;

    localparam logic [4:0]  RST_HOUR   = 5'd0;
    localparam logic [5:0]  RST_MINUTE = 6'd0;
    localparam logic [5:0]  RST_SECOND = 6'd0;
    localparam logic [4:0]  RST_DAY    = 5'd1;
    localparam logic [3:0]  RST_MONTH  = 4'd1;
    localparam logic [11:0] RST_YEAR   = 12'd2025;

    typedef enum logic [4:0] {
        PH_START     = 5'd0,
        PH_I         = 5'd1,
        PH_IP        = 5'd2,
        PH_S         = 5'd3,
        PH_SS        = 5'd4,
        PH_SSI       = 5'd5,
        PH_SSID      = 5'd6,
        PH_P         = 5'd7,
        PH_PN        = 5'd8,
        PH_PND       = 5'd9,
        PH_T         = 5'd10,
        PH_F0        = 5'd11,
        PH_F0S       = 5'd12,
        PH_F1        = 5'd13,
        PH_F1S       = 5'd14,
        PH_F2        = 5'd15,
        PH_F2S       = 5'd16,
        PH_F3        = 5'd17,
        PH_F3S       = 5'd18,
        PH_F4        = 5'd19,
        PH_F4S       = 5'd20,
        PH_F5        = 5'd21,
        PH_F5S       = 5'd22,
        PH_D         = 5'd23,
        PH_DEQ       = 5'd24,
        PH_TIME_DONE = 5'd25,
        PH_DECIDED   = 5'd26
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [1:0]  pot;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_line_end;

    function automatic logic in_range(input logic [FIELD_W-1:0] f,
                                      input logic [ACC_W-1:0] lo,
                                      input logic [ACC_W-1:0] hi);
        logic [ACC_W-1:0] mag;
        mag = f[ACC_W-1:0];
        if (f[ACC_W] && (mag != '0)) begin
            return 1'b0;
        end
        return (mag >= lo) && (mag <= hi);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

/* hdl/stcp_line_parser.sv */
// Per-byte line parser: line counting, keyword matching and number fields.
// Emits one line-end event per non-empty line. Depends on stcp_pkg.
module stcp_line_parser #(
    parameter int LINE_LIMIT = stcp_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_byte_valid,
    input  logic [7:0]           i_byte,
    output stcp_pkg::t_line_end  o_line_end
);

    localparam int CNT_W = $clog2(LINE_LIMIT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_LIMIT - 1);

    logic [CNT_W-1:0]                r_count, n_count;
    logic                            r_zero, n_zero;
    stcp_pkg::t_phase                r_phase, n_phase;
    logic [2:0]                      r_class, n_class;
    logic [stcp_pkg::ACC_W-1:0]      r_accum, n_accum;
    logic                            r_neg, n_neg;
    logic                            r_has_digit, n_has_digit;
    logic [stcp_pkg::FIELD_W-1:0]    r_fields [0:stcp_pkg::NUM_FIELDS-1];
    logic [stcp_pkg::FIELD_W-1:0]    n_fields [0:stcp_pkg::NUM_FIELDS-1];

    logic                            is_term, is_digit, in_number, sgn, f5_pending, time_done;
    logic [4:0]                      off;
    logic [2:0]                      k;
    logic [3:0]                      digit;
    logic [17:0]                     acc_prod;
    logic [stcp_pkg::FIELD_W-1:0]    cur_field, f5;
    logic [2:0]                      fin_kind;
    logic [1:0]                      fin_pot;

    always_comb begin
        is_term   = (i_byte == stcp_pkg::CH_LF) || (i_byte == stcp_pkg::CH_CR);
        is_digit  = (i_byte >= "0") && (i_byte <= "9");
        digit     = 4'(i_byte - "0");
        acc_prod  = 18'(r_accum) * 18'd10 + 18'(digit);
        in_number = (r_phase >= stcp_pkg::PH_F0) && (r_phase <= stcp_pkg::PH_F5S);
        off       = 5'(r_phase) - 5'(stcp_pkg::PH_F0);
        k         = off[3:1];
        sgn       = off[0];
        cur_field = {r_neg, r_accum};

        f5_pending = ((r_phase == stcp_pkg::PH_F5) || (r_phase == stcp_pkg::PH_F5S))
                     && r_has_digit;
        f5        = f5_pending ? cur_field : r_fields[5];
        time_done = (r_phase == stcp_pkg::PH_TIME_DONE) || f5_pending;

        fin_pot = 2'd0;
        if (r_phase == stcp_pkg::PH_DECIDED) begin
            fin_kind = r_class;
            if (r_class == stcp_pkg::KIND_POT) begin
                fin_pot = r_accum[1:0];
            end
        end else if ((r_phase == stcp_pkg::PH_PN) || (r_phase == stcp_pkg::PH_PND)) begin
            fin_kind = stcp_pkg::KIND_POT_BAD;
        end else if (time_done
                     && stcp_pkg::in_range(r_fields[0], 14'd0, 14'd23)
                     && stcp_pkg::in_range(r_fields[1], 14'd0, 14'd59)
                     && stcp_pkg::in_range(r_fields[2], 14'd0, 14'd59)
                     && stcp_pkg::in_range(r_fields[3], 14'd1, 14'd31)
                     && stcp_pkg::in_range(r_fields[4], 14'd1, 14'd12)
                     && stcp_pkg::in_range(f5, 14'd2000, 14'd2099)) begin
            fin_kind = stcp_pkg::KIND_TIME;
        end else begin
            fin_kind = stcp_pkg::KIND_OTHER;
        end

        o_line_end.valid  = i_byte_valid && is_term && (r_count != '0);
        o_line_end.kind   = fin_kind;
        o_line_end.pot    = fin_pot;
        o_line_end.hour   = r_fields[0][4:0];
        o_line_end.minute = r_fields[1][5:0];
        o_line_end.second = r_fields[2][5:0];
        o_line_end.day    = r_fields[3][4:0];
        o_line_end.month  = r_fields[4][3:0];
        o_line_end.year   = f5[11:0];
    end

    always_comb begin
        n_count     = r_count;
        n_zero      = r_zero;
        n_phase     = r_phase;
        n_class     = r_class;
        n_accum     = r_accum;
        n_neg       = r_neg;
        n_has_digit = r_has_digit;
        n_fields    = r_fields;

        if (i_byte_valid) begin
            if (is_term || (r_count == CNT_LAST)) begin
                if (is_term && (r_count != '0) && f5_pending) begin
                    n_fields[5] = cur_field;
                end
                if (is_term || (r_count == CNT_LAST)) begin
                    n_count     = '0;
                    n_zero      = 1'b0;
                    n_phase     = stcp_pkg::PH_START;
                    n_class     = stcp_pkg::KIND_OTHER;
                    n_accum     = '0;
                    n_neg       = 1'b0;
                    n_has_digit = 1'b0;
                end
            end else begin
                n_count = r_count + CNT_W'(1);
                if (r_zero) begin
                    n_zero = 1'b1;
                end else if (i_byte == stcp_pkg::CH_NUL) begin
                    n_zero = 1'b1;
                end else if (in_number) begin
                    if (is_digit) begin
                        n_has_digit = 1'b1;
                        n_accum = (acc_prod > 18'(stcp_pkg::ACC_MAX)) ? stcp_pkg::ACC_MAX
                                                                      : acc_prod[13:0];
                    end else if (r_has_digit) begin
                        n_fields[k] = cur_field;
                        if (k == 3'd5) begin
                            n_phase = stcp_pkg::PH_TIME_DONE;
                        end else if (k == 3'd2) begin
                            if (i_byte == ";") begin
                                n_phase = stcp_pkg::PH_D;
                            end else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end else if (((k < 3'd2) && (i_byte == ":"))
                                     || ((k >= 3'd3) && (i_byte == "/"))) begin
                            n_phase = stcp_pkg::t_phase'(5'(stcp_pkg::PH_F0)
                                                         + {1'b0, k + 3'd1, 1'b0});
                            n_accum     = '0;
                            n_neg       = 1'b0;
                            n_has_digit = 1'b0;
                        end else begin
                            n_phase = stcp_pkg::PH_DECIDED;
                            n_class = stcp_pkg::KIND_OTHER;
                        end
                    end else if (!sgn && stcp_pkg::is_blank(i_byte)) begin
                        n_phase = r_phase;
                    end else if (!sgn && ((i_byte == "+") || (i_byte == "-"))) begin
                        n_neg   = (i_byte == "-");
                        n_phase = stcp_pkg::t_phase'(5'(r_phase) + 5'd1);
                    end else begin
                        n_phase = stcp_pkg::PH_DECIDED;
                        n_class = stcp_pkg::KIND_OTHER;
                    end
                end else begin
                    unique case (r_phase)
                        stcp_pkg::PH_START: begin
                            if (i_byte == "I") n_phase = stcp_pkg::PH_I;
                            else if (i_byte == "S") n_phase = stcp_pkg::PH_S;
                            else if (i_byte == "P") n_phase = stcp_pkg::PH_P;
                            else if (i_byte == "T") n_phase = stcp_pkg::PH_T;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_I: begin
                            if (i_byte == "P") n_phase = stcp_pkg::PH_IP;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_IP: begin
                            n_phase = stcp_pkg::PH_DECIDED;
                            n_class = (i_byte == "=") ? stcp_pkg::KIND_IP
                                                      : stcp_pkg::KIND_OTHER;
                        end
                        stcp_pkg::PH_S: begin
                            if (i_byte == "S") n_phase = stcp_pkg::PH_SS;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_SS: begin
                            if (i_byte == "I") n_phase = stcp_pkg::PH_SSI;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_SSI: begin
                            if (i_byte == "D") n_phase = stcp_pkg::PH_SSID;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_SSID: begin
                            n_phase = stcp_pkg::PH_DECIDED;
                            n_class = (i_byte == "=") ? stcp_pkg::KIND_SSID
                                                      : stcp_pkg::KIND_OTHER;
                        end
                        stcp_pkg::PH_P: begin
                            if (i_byte == "N") n_phase = stcp_pkg::PH_PN;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_PN: begin
                            if ((i_byte >= "1") && (i_byte <= "4")) begin
                                n_accum = {12'd0, 2'(i_byte - "1")};
                                n_phase = stcp_pkg::PH_PND;
                            end else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_POT_BAD;
                            end
                        end
                        stcp_pkg::PH_PND: begin
                            n_phase = stcp_pkg::PH_DECIDED;
                            n_class = (i_byte == "=") ? stcp_pkg::KIND_POT
                                                      : stcp_pkg::KIND_POT_BAD;
                        end
                        stcp_pkg::PH_T, stcp_pkg::PH_DEQ: begin
                            if (i_byte == "=") begin
                                n_phase = (r_phase == stcp_pkg::PH_T) ? stcp_pkg::PH_F0
                                                                      : stcp_pkg::PH_F3;
                                n_accum     = '0;
                                n_neg       = 1'b0;
                                n_has_digit = 1'b0;
                            end else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        stcp_pkg::PH_D: begin
                            if (i_byte == "D") n_phase = stcp_pkg::PH_DEQ;
                            else begin
                                n_phase = stcp_pkg::PH_DECIDED;
                                n_class = stcp_pkg::KIND_OTHER;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_zero      <= 1'b0;
            r_phase     <= stcp_pkg::PH_START;
            r_class     <= stcp_pkg::KIND_OTHER;
            r_accum     <= '0;
            r_neg       <= 1'b0;
            r_has_digit <= 1'b0;
            for (int i = 0; i < stcp_pkg::NUM_FIELDS; i++) begin
                r_fields[i] <= '0;
            end
        end else begin
            r_count     <= n_count;
            r_zero      <= n_zero;
            r_phase     <= n_phase;
            r_class     <= n_class;
            r_accum     <= n_accum;
            r_neg       <= n_neg;
            r_has_digit <= n_has_digit;
            r_fields    <= n_fields;
        end
    end

endmodule

/* hdl/stcp_result_store.sv */
// Stored time, ready flags and the result register of the output channel.
// Loads on each line-end event from stcp_line_parser. Depends on stcp_pkg.
module stcp_result_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stcp_pkg::t_line_end  i_line_end,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [2:0]           o_line_kind,
    output logic [1:0]           o_pot_index,
    output logic                 o_time_valid,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [5:0]           o_second,
    output logic [4:0]           o_day,
    output logic [3:0]           o_month,
    output logic [11:0]          o_year,
    output logic                 o_address_ready,
    output logic                 o_network_name_ready,
    output logic [3:0]           o_pot_names_ready
);

    logic        r_valid, n_valid;
    logic [2:0]  r_kind, n_kind;
    logic [1:0]  r_pot, n_pot;
    logic        r_time_valid, n_time_valid;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [4:0]  r_day, n_day;
    logic [3:0]  r_month, n_month;
    logic [11:0] r_year, n_year;
    logic [5:0]  r_flags, n_flags;

    always_comb begin
        n_valid      = r_valid && i_stall;
        n_kind       = r_kind;
        n_pot        = r_pot;
        n_time_valid = r_time_valid;
        n_hour       = r_hour;
        n_minute     = r_minute;
        n_second     = r_second;
        n_day        = r_day;
        n_month      = r_month;
        n_year       = r_year;
        n_flags      = r_flags;
        if (i_line_end.valid) begin
            n_valid = 1'b1;
            n_kind  = i_line_end.kind;
            n_pot   = i_line_end.pot;
            case (i_line_end.kind)
                stcp_pkg::KIND_TIME: begin
                    n_time_valid = 1'b1;
                    n_hour       = i_line_end.hour;
                    n_minute     = i_line_end.minute;
                    n_second     = i_line_end.second;
                    n_day        = i_line_end.day;
                    n_month      = i_line_end.month;
                    n_year       = i_line_end.year;
                end
                stcp_pkg::KIND_IP:   n_flags[0] = 1'b1;
                stcp_pkg::KIND_SSID: n_flags[1] = 1'b1;
                stcp_pkg::KIND_POT:  n_flags[3'd2 + {1'b0, i_line_end.pot}] = 1'b1;
                default:             n_flags = r_flags;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_kind       <= stcp_pkg::KIND_OTHER;
            r_pot        <= 2'd0;
            r_time_valid <= 1'b0;
            r_hour       <= stcp_pkg::RST_HOUR;
            r_minute     <= stcp_pkg::RST_MINUTE;
            r_second     <= stcp_pkg::RST_SECOND;
            r_day        <= stcp_pkg::RST_DAY;
            r_month      <= stcp_pkg::RST_MONTH;
            r_year       <= stcp_pkg::RST_YEAR;
            r_flags      <= '0;
        end else begin
            r_valid      <= n_valid;
            r_kind       <= n_kind;
            r_pot        <= n_pot;
            r_time_valid <= n_time_valid;
            r_hour       <= n_hour;
            r_minute     <= n_minute;
            r_second     <= n_second;
            r_day        <= n_day;
            r_month      <= n_month;
            r_year       <= n_year;
            r_flags      <= n_flags;
        end
    end

    assign o_valid              = r_valid;
    assign o_line_kind          = r_kind;
    assign o_pot_index          = r_pot;
    assign o_time_valid         = r_time_valid;
    assign o_hour               = r_hour;
    assign o_minute             = r_minute;
    assign o_second             = r_second;
    assign o_day                = r_day;
    assign o_month              = r_month;
    assign o_year               = r_year;
    assign o_address_ready      = r_flags[0];
    assign o_network_name_ready = r_flags[1];
    assign o_pot_names_ready    = r_flags[5:2];

endmodule

/* hdl/serial_time_command_parser.sv */
// Serial time/command line parser, top level: input register, parser, result store.
// Depends on stcp_pkg, stcp_line_parser and stcp_result_store.
// Path: a line terminator passes the input register and the parser into the result
// register, which raises o_valid; the result transfers once i_stall is low.
// Throughput: one byte per cycle, set by the single-pass parser between the input
// register and the result register; stalls only while a held result is stalled.
// Reset: synchronous active low; clears line state, stored time to 00:00:00 01/01/2025.
module serial_time_command_parser #(
    parameter int LINE_LIMIT = stcp_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_line_kind,
    output logic [1:0]  o_pot_index,
    output logic        o_time_valid,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output logic        o_address_ready,
    output logic        o_network_name_ready,
    output logic [3:0]  o_pot_names_ready
);

    logic                r_in_valid, n_in_valid;
    logic [7:0]          r_in_byte, n_in_byte;
    logic                consume, accept;
    stcp_pkg::t_line_end line_end;

    always_comb begin
        consume    = r_in_valid && !(o_valid && i_stall);
        o_stall    = r_in_valid && !consume;
        accept     = i_valid && !o_stall;
        n_in_valid = accept ? 1'b1 : (consume ? 1'b0 : r_in_valid);
        n_in_byte  = accept ? i_rx_byte : r_in_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        r_in_byte <= n_in_byte;
    end

    stcp_line_parser #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (consume),
        .i_byte       (r_in_byte),
        .o_line_end   (line_end)
    );

    stcp_result_store u_store (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_line_end           (line_end),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_line_kind          (o_line_kind),
        .o_pot_index          (o_pot_index),
        .o_time_valid         (o_time_valid),
        .o_hour               (o_hour),
        .o_minute             (o_minute),
        .o_second             (o_second),
        .o_day                (o_day),
        .o_month              (o_month),
        .o_year               (o_year),
        .o_address_ready      (o_address_ready),
        .o_network_name_ready (o_network_name_ready),
        .o_pot_names_ready    (o_pot_names_ready)
    );

endmodule
